FILE: hw/rtl/ccfd_pkg.sv
`timescale 1ns / 1ps

package ccfd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC_RD,
    ST_DEC_PROC,
    ST_DEC_ZERO,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
  localparam logic [1:0] STATUS_COMPLETE   = 2'd1;
  localparam logic [1:0] STATUS_REJECTED   = 2'd2;

  localparam logic [7:0]  MAGIC_0     = 8'h41;
  localparam logic [7:0]  MAGIC_1     = 8'h42;
  localparam logic [7:0]  VERSION     = 8'h01;
  localparam logic [7:0]  RESERVED    = 8'h00;
  localparam logic [7:0]  CODE_FULL   = 8'hff;
  localparam logic [31:0] CRC_POLY    = 32'hedb88320;
  localparam logic [31:0] CRC_INIT    = 32'hffffffff;
  localparam logic [15:0] HDR_BYTES   = 16'd8;
  localparam logic [15:0] CRC_BYTES   = 16'd4;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/ccfd_ram.sv
`timescale 1ns / 1ps

module ccfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cobs_crc_frame_decoder.sv
`timescale 1ns / 1ps
// Channel | Handshake                 | Fields
// in      | in_valid_i / in_stall_o   | wire_byte_i (one byte from the wire per transfer)
// out     | out_valid_o / out_stall_i | status_o, payload_byte_o, pay_len_o, last_o
//
// A nonzero byte or a delimiter that needs no decode is answered with a single result on the output register.
// A delimiter that ends a frame walks the frame memory: a read and a process step per encoded byte,
// a zero step per inserted zero, one check step, then a read and a load step per payload byte.
// Reset clears the fill count, dropping flag and control; the memories are not cleared.
// in_stall_o stays high while a frame is walked or a result is waiting on the output register.

module cobs_crc_frame_decoder
  import ccfd_pkg::*;
#(
  parameter int ENCODED_MAX_BYTES = 128,
  parameter int PAYLOAD_MAX_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] wire_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] payload_byte_o,
  output logic [6:0] pay_len_o,
  output logic       last_o
);

  localparam int PW  = $clog2(ENCODED_MAX_BYTES + 1);
  localparam int EAW = $clog2(ENCODED_MAX_BYTES);
  localparam int PAW = (PAYLOAD_MAX_BYTES > 1) ? $clog2(PAYLOAD_MAX_BYTES) : 1;
  localparam logic [PW-1:0] FULL = PW'(ENCODED_MAX_BYTES);
  localparam logic [15:0]   PMAX = 16'(PAYLOAD_MAX_BYTES);

  state_e state_q, state_d;

  // Frame collection.
  logic [PW-1:0] fill_q, fill_d;
  logic          drop_q, drop_d;

  // Decode walk.
  logic [PW-1:0] rd_q, rd_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    cnt_q, cnt_d;
  logic          ff_q, ff_d;
  logic          fail_q, fail_d;
  logic          hdr_bad_q, hdr_bad_d;
  logic          len_hi_q, len_hi_d;
  logic [7:0]    len_q, len_d;
  logic [31:0]   crc_q, crc_d;
  logic [31:0]   rx_crc_q, rx_crc_d;
  logic [6:0]    idx_q, idx_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [7:0] pbyte_q, pbyte_d;
  logic [6:0] plen_q, plen_d;
  logic       last_q, last_d;

  // Memory ports.
  logic           enc_we, enc_re;
  logic [EAW-1:0] enc_raddr;
  logic [7:0]     enc_rdata;
  logic           pay_we, pay_re;
  logic [PAW-1:0] pay_waddr;
  logic [7:0]     pay_wdata, pay_rdata;

  logic in_xfer, out_free;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Walk helpers.
  logic [15:0] n16, rd1_16, pos16, pidx16, len16;
  logic        code_path, emit, block_end, ff_cur, more, cobs_bad;
  logic [7:0]  dbyte;
  logic        len_ok, frame_ok;

  assign n16    = 16'(fill_q);
  assign rd1_16 = 16'(rd_q) + 16'd1;
  assign pos16  = 16'(pos_q);
  assign pidx16 = pos16 - HDR_BYTES;
  assign len16  = {8'd0, len_q};
  assign code_path = (cnt_q == 8'd0);
  assign more   = rd1_16 < n16;
  assign cobs_bad = code_path &&
                    (enc_rdata == 8'd0 || 16'(enc_rdata) - 16'd1 > n16 - rd1_16);
  assign ff_cur = code_path ? (enc_rdata == CODE_FULL) : ff_q;
  assign block_end = code_path ? (enc_rdata == 8'd1) : (cnt_q == 8'd1);
  assign len_ok = !len_hi_q && len_q != 8'd0 && len16 <= PMAX;
  assign frame_ok = !fail_q && !hdr_bad_q && len_ok &&
                    pos16 == HDR_BYTES + len16 + CRC_BYTES &&
                    rx_crc_q == (crc_q ^ CRC_INIT);

  always_comb begin
    emit  = 1'b0;
    dbyte = 8'd0;
    if (state_q == ST_DEC_PROC && !code_path) begin
      emit  = 1'b1;
      dbyte = enc_rdata;
    end else if (state_q == ST_DEC_ZERO) begin
      emit = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && wire_byte_i == 8'd0 && !drop_q && fill_q != '0) begin
          state_d = ST_DEC_RD;
        end
      end
      ST_DEC_RD: state_d = ST_DEC_PROC;
      ST_DEC_PROC: begin
        if (cobs_bad) begin
          state_d = ST_CHECK;
        end else if (block_end) begin
          if (!ff_cur && more) state_d = ST_DEC_ZERO;
          else if (more)       state_d = ST_DEC_RD;
          else                 state_d = ST_CHECK;
        end else begin
          state_d = more ? ST_DEC_RD : ST_CHECK;
        end
      end
      ST_DEC_ZERO: state_d = (16'(rd_q) < n16) ? ST_DEC_RD : ST_CHECK;
      ST_CHECK:    state_d = frame_ok ? ST_EMIT_RD : ST_IDLE;
      ST_EMIT_RD:  if (out_free) state_d = ST_EMIT_LD;
      ST_EMIT_LD:  state_d = (idx_q + 7'd1 == len_q[6:0]) ? ST_IDLE : ST_EMIT_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    fill_d = fill_q;  drop_d = drop_q;
    rd_d = rd_q;  pos_d = pos_q;  cnt_d = cnt_q;  ff_d = ff_q;
    fail_d = fail_q;  hdr_bad_d = hdr_bad_q;  len_hi_d = len_hi_q;  len_d = len_q;
    crc_d = crc_q;  rx_crc_d = rx_crc_q;  idx_d = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q;  pbyte_d = pbyte_q;  plen_d = plen_q;  last_d = last_q;
    enc_we = 1'b0;  enc_re = 1'b0;  enc_raddr = rd_q[EAW-1:0];
    pay_we = 1'b0;  pay_re = 1'b0;
    pay_waddr = pidx16[PAW-1:0];  pay_wdata = dbyte;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          out_valid_d = 1'b1;
          status_d = STATUS_INCOMPLETE;
          pbyte_d = 8'd0;  plen_d = 7'd0;  last_d = 1'b1;
          if (wire_byte_i != 8'd0) begin
            if (!drop_q) begin
              if (fill_q == FULL) begin
                fill_d = '0;  drop_d = 1'b1;
                status_d = STATUS_REJECTED;
              end else begin
                enc_we = 1'b1;
                fill_d = fill_q + PW'(1);
              end
            end
          end else if (drop_q) begin
            drop_d = 1'b0;
          end else if (fill_q != '0) begin
            // Start the walk; the check then gives a rejection or starts the payload output.
            out_valid_d = 1'b0;
            rd_d = '0;  pos_d = '0;  cnt_d = 8'd0;  ff_d = 1'b0;
            fail_d = 1'b0;  hdr_bad_d = 1'b0;  len_hi_d = 1'b0;  len_d = 8'd0;
            crc_d = CRC_INIT;
          end
        end
      end
      ST_DEC_RD: enc_re = 1'b1;
      ST_DEC_PROC: begin
        rd_d = PW'(rd1_16);
        if (cobs_bad) begin
          fail_d = 1'b1;
        end else if (code_path) begin
          cnt_d = enc_rdata - 8'd1;
          ff_d  = ff_cur;
        end else begin
          cnt_d = cnt_q - 8'd1;
        end
      end
      ST_CHECK: begin
        fill_d = '0;
        idx_d  = 7'd0;
        if (!frame_ok) begin
          out_valid_d = 1'b1;
          status_d = STATUS_REJECTED;
          pbyte_d = 8'd0;  plen_d = 7'd0;  last_d = 1'b1;
        end
      end
      ST_EMIT_RD: pay_re = out_free;
      ST_EMIT_LD: begin
        out_valid_d = 1'b1;
        status_d = STATUS_COMPLETE;
        pbyte_d  = pay_rdata;
        plen_d   = len_q[6:0];
        last_d   = (idx_q + 7'd1 == len_q[6:0]);
        idx_d    = idx_q + 7'd1;
      end
      default: ;
    endcase

    // Consume one decoded byte: header check, length, CRC, payload store, received CRC capture.
    if (emit) begin
      pos_d = pos_q + PW'(1);
      if (pos16 < 16'd4) begin
        case (pos16[1:0])
          2'd0: if (dbyte != MAGIC_0) hdr_bad_d = 1'b1;
          2'd1: if (dbyte != MAGIC_1) hdr_bad_d = 1'b1;
          2'd2: if (dbyte != VERSION) hdr_bad_d = 1'b1;
          default: if (dbyte != RESERVED) hdr_bad_d = 1'b1;
        endcase
      end else if (pos16 < 16'd7) begin
        if (dbyte != 8'd0) len_hi_d = 1'b1;
      end else if (pos16 == 16'd7) begin
        len_d = dbyte;
      end
      if (pos16 < HDR_BYTES || pidx16 < len16) begin
        crc_d = crc_byte(crc_q, dbyte);
      end
      if (pos16 >= HDR_BYTES && pidx16 < len16 && len_ok) begin
        pay_we = 1'b1;
      end
      if (pos16 >= HDR_BYTES && pidx16 >= len16 && pidx16 < len16 + CRC_BYTES) begin
        rx_crc_d = {rx_crc_q[23:0], dbyte};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;  pos_q <= pos_d;  cnt_q <= cnt_d;  ff_q <= ff_d;
    fail_q <= fail_d;  hdr_bad_q <= hdr_bad_d;  len_hi_q <= len_hi_d;  len_q <= len_d;
    crc_q <= crc_d;  rx_crc_q <= rx_crc_d;  idx_q <= idx_d;
    status_q <= status_d;  pbyte_q <= pbyte_d;  plen_q <= plen_d;  last_q <= last_d;
  end

  ccfd_ram #(.WIDTH(8), .DEPTH(ENCODED_MAX_BYTES), .AW(EAW)) u_enc_ram (
    .clk_i   (clk_i),
    .we_i    (enc_we),
    .waddr_i (fill_q[EAW-1:0]),
    .wdata_i (wire_byte_i),
    .re_i    (enc_re),
    .raddr_i (enc_raddr),
    .rdata_o (enc_rdata)
  );

  ccfd_ram #(.WIDTH(8), .DEPTH(PAYLOAD_MAX_BYTES), .AW(PAW)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .re_i    (pay_re),
    .raddr_i (idx_q[PAW-1:0]),
    .rdata_o (pay_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign payload_byte_o = pbyte_q;
  assign pay_len_o      = plen_q;
  assign last_o         = last_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL) else $error("fill count past memory depth");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_COMPLETE |-> last_o && payload_byte_o == 8'd0 &&
    pay_len_o == 7'd0) else $error("single result malformed");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> state_q == ST_IDLE) else $error("byte taken during frame walk");

  a_emit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_COMPLETE |-> pay_len_o != 7'd0 &&
    16'(pay_len_o) <= PMAX) else $error("completed length out of range");

endmodule
